// ===== design/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Types and constants shared by the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned INDEX_W     = 32;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned MASK_W      = 32;
  localparam int unsigned WORD_BYTES  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_0_7   = 3'd0,
    CFG_PATTERN_8_15  = 3'd1,
    CFG_PATTERN_16_23 = 3'd2,
    CFG_PATTERN_24_31 = 3'd3,
    CFG_WILDCARD_MASK = 3'd4,
    CFG_PATTERN_LEN   = 3'd5,
    CFG_RANGE_BASE    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_range;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_word_t;

  typedef struct packed {
    logic              advance;
    logic              clear;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  last_pos;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/wbps_stream_if.sv =====
// ----------------------------------------------------------------------------
// wbps_stream_if
// Valid/ready channel carrying one word of the given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbps_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/wbps_cell.sv =====
// ----------------------------------------------------------------------------
// wbps_cell
// One pattern position: compares the incoming byte and keeps the partial
// match bit for the prefix that ends at this position.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cell
  import wbps_pkg::*;
#(
  parameter int unsigned POS = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [BYTE_W-1:0] pattern_byte,
  input  wire logic              wild,
  input  wire logic              prev_match,
  output logic                   match,
  output logic                   tail_hit
);

  logic live;
  logic is_tail;
  logic match_next;

  assign live       = LEN_W'(POS) <= ctrl.last_pos;
  assign is_tail    = LEN_W'(POS) == ctrl.last_pos;
  assign match_next = prev_match & live & (wild | (pattern_byte == ctrl.data_byte));
  assign tail_hit   = match_next & is_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.clear) begin
      match <= 1'b0;
    end else if (ctrl.advance) begin
      match <= match_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/wildcard_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Leftmost wildcard pattern search over a byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and returns, for each range, either the
// address of the first full match (range base plus offset of its first byte)
// or a not-found word when the range ends without one; after a match the
// rest of the range is consumed silently. Every pattern position is a cell
// of a chain that compares the byte and passes its partial match bit to the
// next cell, so all candidate starts, overlapping ones included, are tracked
// at once. A result leaves through an output register, and input keeps
// flowing while that register is empty or drained in the same cycle.
// Configuration writes apply from the next byte on.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scanner
  import wbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  wbps_stream_if.sink                 scan_in,
  wbps_stream_if.source               scan_out
);

  logic [BYTE_W-1:0]      pattern [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] wild;
  logic [LEN_W-1:0]       pattern_len;
  logic [ADDR_W-1:0]      range_base;

  logic [INDEX_W-1:0]     byte_index;
  logic                   match_reported;
  logic                   out_valid;
  out_word_t              out_word;

  logic [LEN_W-1:0]       last_pos;
  logic                   accept;
  logic                   last_byte;
  logic                   hit_any;
  logic                   found_now;
  logic                   miss_now;
  cell_ctrl_t             ctrl;
  logic [MAX_PATTERN-1:0] cell_match;
  logic [MAX_PATTERN-1:0] cell_tail;
  in_word_t               in_word;

  assign in_word = scan_in.data;

  always_comb begin
    priority if (pattern_len == '0) begin
      last_pos = '0;
    end else if (pattern_len > LEN_W'(MAX_PATTERN)) begin
      last_pos = LEN_W'(MAX_PATTERN - 1);
    end else begin
      last_pos = pattern_len - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        pattern[k] <= '0;
      end
      wild        <= '0;
      pattern_len <= LEN_W'(1);
      range_base  <= '0;
    end else if (cfg_write) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (cfg_index == CFG_INDEX_W'(k / WORD_BYTES)) begin
          pattern[k] <= cfg_data[(k % WORD_BYTES) * BYTE_W +: BYTE_W];
        end
      end
      unique case (cfg_index)
        CFG_WILDCARD_MASK: wild        <= cfg_data[MAX_PATTERN-1:0];
        CFG_PATTERN_LEN:   pattern_len <= cfg_data[LEN_W-1:0];
        CFG_RANGE_BASE:    range_base  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign scan_in.ready = !out_valid || scan_out.ready;
  assign accept        = scan_in.valid && scan_in.ready;
  assign last_byte     = in_word.end_of_range;

  assign ctrl.advance   = accept && !match_reported;
  assign ctrl.clear     = accept && last_byte;
  assign ctrl.data_byte = in_word.data_byte;
  assign ctrl.last_pos  = last_pos;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = cell_match[k-1];
    end
    wbps_cell #(
      .POS (k)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .pattern_byte (pattern[k]),
      .wild         (wild[k]),
      .prev_match   (prev),
      .match        (cell_match[k]),
      .tail_hit     (cell_tail[k])
    );
  end

  assign hit_any   = |cell_tail;
  assign found_now = accept && !match_reported && hit_any;
  assign miss_now  = accept && !match_reported && !hit_any && last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index     <= '0;
      match_reported <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_index     <= '0;
        match_reported <= 1'b0;
      end else begin
        if (byte_index != '1) begin
          byte_index <= byte_index + INDEX_W'(1);
        end
        if (found_now) begin
          match_reported <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (found_now || miss_now) begin
      out_valid <= 1'b1;
    end else if (scan_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (found_now || miss_now) begin
      out_word.found <= found_now;
      if (found_now) begin
        out_word.match_address <= range_base + ADDR_W'(byte_index) - ADDR_W'(last_pos);
      end else begin
        out_word.match_address <= '0;
      end
    end
  end

  assign scan_out.valid = out_valid;
  assign scan_out.data  = out_word;

endmodule

`default_nettype wire
